// ===== rtl/core/evq_pkg.sv =====
// Shared types, codes and a byte-mask helper function for the event queue dispatcher.
package evq_pkg;

  localparam int unsigned EV_W     = 8;
  localparam int unsigned HD_W     = 8;
  localparam int unsigned PL_W     = 64;
  localparam int unsigned SZ_W     = 4;
  localparam int unsigned ST_W     = 3;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned PL_BYTES = 8;
  localparam int unsigned Q_DW     = EV_W + SZ_W + PL_W;

  typedef enum logic [OP_W-1:0] {
    OP_NEW_ID   = 3'd0,
    OP_SUB      = 3'd1,
    OP_UNSUB    = 3'd2,
    OP_RAISE    = 3'd3,
    OP_DISPATCH = 3'd4,
    OP_CLEAR    = 3'd5
  } evq_op_e;

  typedef enum logic [ST_W-1:0] {
    STS_OK          = 3'd0,
    STS_TABLE_FULL  = 3'd1,
    STS_NOT_FOUND   = 3'd2,
    STS_QUEUE_FULL  = 3'd3,
    STS_TOO_LARGE   = 3'd4,
    STS_EMPTY       = 3'd5,
    STS_IDS_EXHAUST = 3'd6
  } evq_status_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic clr;
    logic sel;
  } evq_qctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } evq_qstat_t;

  function automatic logic [PL_W-1:0] evq_byte_mask(input logic [SZ_W-1:0] n);
    logic [PL_W-1:0] m;
    m = '0;
    for (int b = 0; b < PL_BYTES; b++) begin
      if (b < int'(n)) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/evq_queue.sv =====
// Ring queues of pending events for both loops, held in one synchronous memory.
module evq_queue import evq_pkg::*; #(
  parameter int unsigned QUEUE_SLOTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  evq_qctl_t        ctrl_i,
  input  logic [EV_W-1:0]  ev_i,
  input  logic [SZ_W-1:0]  sz_i,
  input  logic [PL_W-1:0]  pl_i,
  output evq_qstat_t       stat_o,
  output logic [EV_W-1:0]  ev_o,
  output logic [SZ_W-1:0]  sz_o,
  output logic [PL_W-1:0]  pl_o
);

  localparam int unsigned QW = $clog2(QUEUE_SLOTS);

  logic [QW-1:0]   head_q [2];
  logic [QW-1:0]   tail_q [2];
  logic [Q_DW-1:0] mem [2][QUEUE_SLOTS];
  logic [Q_DW-1:0] rd_q;
  logic [QW-1:0]   head_nxt;
  logic [QW-1:0]   tail_nxt;

  assign head_nxt = (head_q[ctrl_i.sel] == QW'(QUEUE_SLOTS - 1)) ? '0
                  : head_q[ctrl_i.sel] + 1'b1;
  assign tail_nxt = (tail_q[ctrl_i.sel] == QW'(QUEUE_SLOTS - 1)) ? '0
                  : tail_q[ctrl_i.sel] + 1'b1;

  assign stat_o.full  = (tail_nxt == head_q[ctrl_i.sel]);
  assign stat_o.empty = (tail_q[ctrl_i.sel] == head_q[ctrl_i.sel]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '{default: '0};
      tail_q <= '{default: '0};
    end else begin
      if (ctrl_i.clr) begin
        head_q[ctrl_i.sel] <= '0;
        tail_q[ctrl_i.sel] <= '0;
      end else begin
        if (ctrl_i.push) begin
          tail_q[ctrl_i.sel] <= tail_nxt;
        end
        if (ctrl_i.pop) begin
          head_q[ctrl_i.sel] <= head_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[ctrl_i.sel][tail_q[ctrl_i.sel]] <= {pl_i, sz_i, ev_i};
    end
    if (ctrl_i.pop) begin
      rd_q <= mem[ctrl_i.sel][head_q[ctrl_i.sel]];
    end
  end

  assign ev_o = rd_q[EV_W-1:0];
  assign sz_o = rd_q[EV_W +: SZ_W];
  assign pl_o = rd_q[EV_W+SZ_W +: PL_W];

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> !stat_o.empty) else $error("pop from an empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> !stat_o.full) else $error("push into a full queue");
`endif

endmodule

// ===== rtl/core/event_queue_dispatcher_core.sv =====
// Top level: two publish/subscribe event loops with table scan and result output.
// New id, raise and clear pass from transfer through the execute and response states to the result.
// Subscribe, unsubscribe and dispatch scan the subscription table one entry a cycle
// through its memory read port, except while a dispatch stall holds the scan.
// One item is worked on at a time; a dispatch stalls its scan while the output waits.
// Reset empties both loops at once; no clearing pass is needed.
module event_queue_dispatcher_core import evq_pkg::*; #(
  parameter int unsigned QUEUE_SLOTS   = 16,
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned ID_BITS       = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // evt_code[7:0], handler_id[15:8], payload[79:16], payload_size[83:80]
  input  logic [87:0] s_axis_tdata_i,
  // operation[2:0], loop_select[3]
  input  logic [3:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[2:0], new_id[10:3], out_evt_code[18:11], out_handler[26:19],
  // out_payload[90:27], out_size[94:91]
  output logic [95:0] m_axis_tdata_o,
  // handler_valid[0]
  output logic [0:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam int unsigned TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_RESP   = 5'b01000,
    ST_FINISH = 5'b10000
  } evq_state_e;

  evq_state_e state_q, state_d;

  logic [OP_W-1:0] op_q;
  logic            sel_q;
  logic [EV_W-1:0] ev_q;
  logic [HD_W-1:0] hd_q;
  logic [PL_W-1:0] pl_q;
  logic [SZ_W-1:0] sz_q;

  logic [ID_BITS-1:0]       cnt_q [2];
  logic [TABLE_ENTRIES-1:0] used_q [2];
  logic [EV_W+HD_W-1:0]     tbl_mem [2][TABLE_ENTRIES];

  logic          iss_vld_q, iss_vld_d;
  logic [TW-1:0] iss_idx_q, iss_idx_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [TW-1:0] cmp_idx_q;
  logic [EV_W-1:0] cmp_ev_q;
  logic [HD_W-1:0] cmp_hd_q;
  logic          cmp_used_q;
  logic          free_fnd_q, free_fnd_d;
  logic [TW-1:0] free_idx_q;
  logic          held_vld_q, held_vld_d;
  logic [HD_W-1:0] held_hd_q;

  evq_status_e     res_status_q, res_status_d;
  logic [7:0]      res_newid_q, res_newid_d;

  logic accept, out_free, tbl_re, tbl_we, start_scan;
  logic cnt_inc, cnt_clr, used_set, used_unset;
  logic is_disp, match, stall, scan_end;
  logic [EV_W-1:0] key_ev;

  evq_qctl_t       qctl;
  evq_qstat_t      qstat;
  logic [EV_W-1:0] q_ev;
  logic [SZ_W-1:0] q_sz;
  logic [PL_W-1:0] q_pl;

  logic            emit;
  evq_status_e     e_status;
  logic [7:0]      e_newid;
  logic [EV_W-1:0] e_ev;
  logic [HD_W-1:0] e_hd;
  logic            e_hv;
  logic [PL_W-1:0] e_pl;
  logic [SZ_W-1:0] e_sz;
  logic            e_last;

  logic            out_vld_q;
  evq_status_e     out_status_q;
  logic [7:0]      out_newid_q;
  logic [EV_W-1:0] out_ev_q;
  logic [HD_W-1:0] out_hd_q;
  logic            out_hv_q;
  logic [PL_W-1:0] out_pl_q;
  logic [SZ_W-1:0] out_sz_q;
  logic            out_last_q;

  assign s_axis_tready_o = state_q == ST_IDLE;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;

  evq_queue #(
    .QUEUE_SLOTS(QUEUE_SLOTS)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (qctl),
    .ev_i   (ev_q),
    .sz_i   (sz_q),
    .pl_i   (pl_q & evq_byte_mask(sz_q)),
    .stat_o (qstat),
    .ev_o   (q_ev),
    .sz_o   (q_sz),
    .pl_o   (q_pl)
  );

  assign is_disp  = op_q == OP_DISPATCH;
  assign key_ev   = is_disp ? q_ev : ev_q;
  assign match    = cmp_vld_q && cmp_used_q && (cmp_ev_q == key_ev)
                 && (is_disp || (cmp_hd_q == hd_q));
  assign stall    = is_disp && match && held_vld_q && !out_free;
  assign scan_end = !iss_vld_q && !cmp_vld_q;

  always_comb begin
    state_d      = state_q;
    res_status_d = res_status_q;
    res_newid_d  = res_newid_q;
    qctl         = '{push: 1'b0, pop: 1'b0, clr: 1'b0, sel: sel_q};
    cnt_inc      = 1'b0;
    cnt_clr      = 1'b0;
    used_set     = 1'b0;
    used_unset   = 1'b0;
    tbl_we       = 1'b0;
    tbl_re       = 1'b0;
    start_scan   = 1'b0;
    iss_vld_d    = iss_vld_q;
    iss_idx_d    = iss_idx_q;
    cmp_vld_d    = cmp_vld_q;
    free_fnd_d   = free_fnd_q;
    held_vld_d   = held_vld_q;
    emit         = 1'b0;
    e_status     = STS_OK;
    e_newid      = '0;
    e_ev         = '0;
    e_hd         = '0;
    e_hv         = 1'b0;
    e_pl         = '0;
    e_sz         = '0;
    e_last       = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && s_axis_tuser_i[2:0] <= OP_CLEAR) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d      = ST_RESP;
        res_status_d = STS_OK;
        res_newid_d  = '0;
        unique case (op_q)
          OP_NEW_ID: begin
            if (&cnt_q[sel_q]) begin
              res_status_d = STS_IDS_EXHAUST;
            end else begin
              res_newid_d = 8'(cnt_q[sel_q]);
              cnt_inc     = 1'b1;
            end
          end
          OP_RAISE: begin
            if (qstat.full) begin
              res_status_d = STS_QUEUE_FULL;
            end else if (sz_q > SZ_W'(PL_BYTES)) begin
              res_status_d = STS_TOO_LARGE;
            end else begin
              qctl.push = 1'b1;
            end
          end
          OP_CLEAR: begin
            qctl.clr = 1'b1;
            cnt_clr  = 1'b1;
          end
          OP_DISPATCH: begin
            if (qstat.empty) begin
              res_status_d = STS_EMPTY;
            end else begin
              qctl.pop   = 1'b1;
              start_scan = 1'b1;
              state_d    = ST_SCAN;
            end
          end
          default: begin
            start_scan = 1'b1;
            state_d    = ST_SCAN;
          end
        endcase
        if (start_scan) begin
          iss_vld_d  = 1'b1;
          iss_idx_d  = '0;
          cmp_vld_d  = 1'b0;
          free_fnd_d = 1'b0;
          held_vld_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          tbl_re    = iss_vld_q;
          cmp_vld_d = iss_vld_q;
          if (iss_vld_q) begin
            if (iss_idx_q == TW'(TABLE_ENTRIES - 1)) begin
              iss_vld_d = 1'b0;
            end else begin
              iss_idx_d = iss_idx_q + 1'b1;
            end
          end
        end
        priority if (scan_end) begin
          res_status_d = STS_OK;
          res_newid_d  = '0;
          if (op_q == OP_SUB) begin
            state_d = ST_RESP;
            if (free_fnd_q) begin
              tbl_we   = 1'b1;
              used_set = 1'b1;
            end else begin
              res_status_d = STS_TABLE_FULL;
            end
          end else if (op_q == OP_UNSUB) begin
            state_d      = ST_RESP;
            res_status_d = STS_NOT_FOUND;
          end else begin
            state_d = ST_FINISH;
          end
        end else if (match && !is_disp) begin
          res_status_d = STS_OK;
          res_newid_d  = '0;
          state_d      = ST_RESP;
          used_unset   = op_q == OP_UNSUB;
        end else if (match && !stall) begin
          held_vld_d = 1'b1;
          if (held_vld_q) begin
            emit   = 1'b1;
            e_ev   = q_ev;
            e_hd   = held_hd_q;
            e_hv   = 1'b1;
            e_pl   = q_pl;
            e_sz   = q_sz;
            e_last = 1'b0;
          end
        end else begin
          if (cmp_vld_q && !cmp_used_q && !free_fnd_q) begin
            free_fnd_d = 1'b1;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          emit     = 1'b1;
          e_status = res_status_q;
          e_newid  = res_newid_q;
          state_d  = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          emit       = 1'b1;
          e_ev       = q_ev;
          e_hd       = held_vld_q ? held_hd_q : '0;
          e_hv       = held_vld_q;
          e_pl       = q_pl;
          e_sz       = q_sz;
          held_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '{default: '0};
      used_q     <= '{default: '0};
      iss_vld_q  <= 1'b0;
      iss_idx_q  <= '0;
      cmp_vld_q  <= 1'b0;
      free_fnd_q <= 1'b0;
      held_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      iss_vld_q  <= iss_vld_d;
      iss_idx_q  <= iss_idx_d;
      cmp_vld_q  <= cmp_vld_d;
      free_fnd_q <= free_fnd_d;
      held_vld_q <= held_vld_d;
      out_vld_q  <= emit || (out_vld_q && !m_axis_tready_i);
      if (cnt_clr) begin
        cnt_q[sel_q]  <= '0;
        used_q[sel_q] <= '0;
      end else if (cnt_inc) begin
        cnt_q[sel_q] <= cnt_q[sel_q] + 1'b1;
      end
      if (used_set) begin
        used_q[sel_q][free_idx_q] <= 1'b1;
      end
      if (used_unset) begin
        used_q[sel_q][cmp_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= s_axis_tuser_i[2:0];
      sel_q <= s_axis_tuser_i[3];
      ev_q  <= s_axis_tdata_i[7:0];
      hd_q  <= s_axis_tdata_i[15:8];
      pl_q  <= s_axis_tdata_i[79:16];
      sz_q  <= s_axis_tdata_i[83:80];
    end
    res_status_q <= res_status_d;
    res_newid_q  <= res_newid_d;
    if (tbl_we) begin
      tbl_mem[sel_q][free_idx_q] <= {hd_q, ev_q};
    end
    if (tbl_re) begin
      {cmp_hd_q, cmp_ev_q} <= tbl_mem[sel_q][iss_idx_q];
      cmp_used_q           <= used_q[sel_q][iss_idx_q];
      cmp_idx_q            <= iss_idx_q;
    end
    if (state_q == ST_SCAN && cmp_vld_q && !cmp_used_q && !free_fnd_q) begin
      free_idx_q <= cmp_idx_q;
    end
    if (state_q == ST_SCAN && match && is_disp && !stall) begin
      held_hd_q <= cmp_hd_q;
    end
    if (emit) begin
      out_status_q <= e_status;
      out_newid_q  <= e_newid;
      out_ev_q     <= e_ev;
      out_hd_q     <= e_hd;
      out_hv_q     <= e_hv;
      out_pl_q     <= e_pl;
      out_sz_q     <= e_sz;
      out_last_q   <= e_last;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_sz_q, out_pl_q, out_hd_q, out_ev_q, out_newid_q,
                            out_status_q};
  assign m_axis_tuser_o  = out_hv_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free) else $error("result overwrites a pending output");
  a_held_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_vld_q |-> is_disp) else $error("held match outside a dispatch");
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_clr |=> (used_q[sel_q] == '0) && (cnt_q[sel_q] == '0))
    else $error("clear left state behind");
  a_scan_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !e_last) |-> (state_q == ST_SCAN)) else $error("stray non-final result");
`endif

endmodule

// ===== tb/sv/tb_event_queue_dispatcher_core.sv =====
// Self-checking testbench for the two-loop event queue dispatcher core.
`timescale 1ns / 100ps

class evq_scoreboard;
  typedef struct {
    logic [2:0]  status;
    logic [7:0]  new_id;
    logic [7:0]  ev;
    logic [7:0]  hd;
    logic        hv;
    logic [63:0] pl;
    logic [3:0]  sz;
    logic        last;
  } evq_result_t;

  logic [7:0]  q_ev [2][16];
  logic [3:0]  q_sz [2][16];
  logic [63:0] q_pl [2][16];
  int unsigned q_head [2];
  int unsigned q_tail [2];
  int unsigned id_cnt [2];
  bit          used [2][32];
  logic [7:0]  t_ev [2][32];
  logic [7:0]  t_hd [2][32];
  evq_result_t pending_results[$];
  int          errors;

  function new();
    errors = 0;
    for (int l = 0; l < 2; l++) wipe(l);
  endfunction

  function void wipe(int l);
    q_head[l] = 0;
    q_tail[l] = 0;
    id_cnt[l] = 0;
    for (int i = 0; i < 32; i++) used[l][i] = 0;
  endfunction

  function void push_result(logic [2:0] st, logic [7:0] nid, logic [7:0] ev,
                            logic [7:0] hd, logic hv, logic [63:0] pl,
                            logic [3:0] sz, logic last);
    evq_result_t r;
    r.status = st; r.new_id = nid; r.ev = ev; r.hd = hd; r.hv = hv;
    r.pl = pl; r.sz = sz; r.last = last;
    pending_results.push_back(r);
  endfunction

  function int queue_count(int l);
    return (q_tail[l] + 16 - q_head[l]) % 16;
  endfunction

  function void note_input(logic [2:0] op, logic sel, logic [7:0] ev, logic [7:0] hd,
                           logic [63:0] pl, logic [3:0] sz);
    int l;
    int n;
    int h;
    logic [63:0] m;
    l = sel;
    case (op)
      evq_pkg::OP_NEW_ID: begin
        if (id_cnt[l] >= 255) push_result(evq_pkg::STS_IDS_EXHAUST, 0, 0, 0, 0, 0, 0, 1);
        else begin
          push_result(evq_pkg::STS_OK, 8'(id_cnt[l]), 0, 0, 0, 0, 0, 1);
          id_cnt[l]++;
        end
      end
      evq_pkg::OP_SUB: begin
        for (int i = 0; i < 32; i++)
          if (used[l][i] && t_ev[l][i] == ev && t_hd[l][i] == hd) begin
            push_result(evq_pkg::STS_OK, 0, 0, 0, 0, 0, 0, 1);
            return;
          end
        for (int i = 0; i < 32; i++)
          if (!used[l][i]) begin
            used[l][i] = 1; t_ev[l][i] = ev; t_hd[l][i] = hd;
            push_result(evq_pkg::STS_OK, 0, 0, 0, 0, 0, 0, 1);
            return;
          end
        push_result(evq_pkg::STS_TABLE_FULL, 0, 0, 0, 0, 0, 0, 1);
      end
      evq_pkg::OP_UNSUB: begin
        for (int i = 0; i < 32; i++)
          if (used[l][i] && t_ev[l][i] == ev && t_hd[l][i] == hd) begin
            used[l][i] = 0;
            push_result(evq_pkg::STS_OK, 0, 0, 0, 0, 0, 0, 1);
            return;
          end
        push_result(evq_pkg::STS_NOT_FOUND, 0, 0, 0, 0, 0, 0, 1);
      end
      evq_pkg::OP_RAISE: begin
        if ((q_tail[l] + 1) % 16 == q_head[l])
          push_result(evq_pkg::STS_QUEUE_FULL, 0, 0, 0, 0, 0, 0, 1);
        else if (sz > 8) push_result(evq_pkg::STS_TOO_LARGE, 0, 0, 0, 0, 0, 0, 1);
        else begin
          m = '0;
          for (int b = 0; b < 8; b++) if (b < sz) m[b*8 +: 8] = 8'hFF;
          q_ev[l][q_tail[l]] = ev; q_sz[l][q_tail[l]] = sz;
          q_pl[l][q_tail[l]] = pl & m;
          q_tail[l] = (q_tail[l] + 1) % 16;
          push_result(evq_pkg::STS_OK, 0, 0, 0, 0, 0, 0, 1);
        end
      end
      evq_pkg::OP_DISPATCH: begin
        if (q_head[l] == q_tail[l]) begin
          push_result(evq_pkg::STS_EMPTY, 0, 0, 0, 0, 0, 0, 1);
          return;
        end
        h = q_head[l];
        q_head[l] = (h + 1) % 16;
        n = 0;
        for (int i = 0; i < 32; i++)
          if (used[l][i] && t_ev[l][i] == q_ev[l][h]) begin
            push_result(evq_pkg::STS_OK, 0, q_ev[l][h], t_hd[l][i], 1, q_pl[l][h],
                        q_sz[l][h], 0);
            n++;
          end
        if (n == 0) push_result(evq_pkg::STS_OK, 0, q_ev[l][h], 0, 0, q_pl[l][h], q_sz[l][h], 1);
        else pending_results[$].last = 1;
      end
      evq_pkg::OP_CLEAR: begin
        wipe(l);
        push_result(evq_pkg::STS_OK, 0, 0, 0, 0, 0, 0, 1);
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [95:0] d, logic hv, logic last);
    evq_result_t e;
    if (pending_results.size() == 0) begin
      $error("result with no expectation: tdata=%h", d);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (d[2:0] !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, d[2:0]); errors++;
    end
    if (d[10:3] !== e.new_id) begin
      $error("new_id: expected %0d, actual %0d", e.new_id, d[10:3]); errors++;
    end
    if (d[18:11] !== e.ev) begin
      $error("out_evt_code: expected %0d, actual %0d", e.ev, d[18:11]); errors++;
    end
    if (d[26:19] !== e.hd) begin
      $error("out_handler: expected %0d, actual %0d", e.hd, d[26:19]); errors++;
    end
    if (hv !== e.hv) begin
      $error("handler_valid: expected %0d, actual %0d", e.hv, hv); errors++;
    end
    if (d[90:27] !== e.pl) begin
      $error("out_payload: expected %h, actual %h", e.pl, d[90:27]); errors++;
    end
    if (d[94:91] !== e.sz) begin
      $error("out_size: expected %0d, actual %0d", e.sz, d[94:91]); errors++;
    end
    if (last !== e.last) begin
      $error("last: expected %0d, actual %0d", e.last, last); errors++;
    end
  endfunction
endclass

module tb_event_queue_dispatcher_core;
  import evq_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [87:0] s_axis_tdata_i;
  logic [3:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [95:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  evq_scoreboard dispatch_sb;
  int unsigned   idle_cycles;

  event_queue_dispatcher_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(evq_op_e op, logic sel, logic [7:0] ev, logic [7:0] hd,
                           logic [63:0] pl, logic [3:0] sz);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, sz, pl, hd, ev};
    s_axis_tuser_i  <= {sel, op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    dispatch_sb.note_input(op, sel, ev, hd, pl, sz);
  endtask

  task automatic send_raw(logic [2:0] op, logic sel);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= 88'({$urandom, $urandom, $urandom});
    s_axis_tuser_i  <= {sel, op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    dispatch_sb.note_input(op, sel, 0, 0, 0, 0);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        dispatch_sb.check_result(m_axis_tdata_o, m_axis_tuser_o[0], m_axis_tlast_o);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
      if ($urandom_range(0, 99) < 2) m_axis_tready_i <= 1'b0;
      else if ($urandom_range(0, 99) < 40) m_axis_tready_i <= ~m_axis_tready_i;
    end else begin
      idle_cycles     <= 0;
      m_axis_tready_i <= 1'b1;
    end
  end

  initial begin
    logic [7:0] ev;
    int         k;
    dispatch_sb     = new();
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_item(OP_NEW_ID, 0, 0, 0, 0, 0);
    send_item(OP_NEW_ID, 1, 0, 0, 0, 0);
    send_item(OP_SUB, 0, 8'hFF, 8'hFF, 0, 0);
    send_item(OP_SUB, 0, 8'hFF, 8'hFF, 0, 0);
    send_item(OP_SUB, 0, 8'hFF, 8'h00, 0, 0);
    send_item(OP_SUB, 1, 8'h00, 8'hAA, 0, 0);
    send_item(OP_UNSUB, 0, 8'h12, 8'h34, 0, 0);
    send_item(OP_RAISE, 0, 8'hFF, 0, 64'hFFFF_FFFF_FFFF_FFFF, 8);
    send_item(OP_RAISE, 0, 8'h00, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_item(OP_RAISE, 0, 8'hFF, 0, 64'h0123_4567_89AB_CDEF, 3);
    send_item(OP_RAISE, 0, 8'h01, 0, 64'hFFFF_FFFF_FFFF_FFFF, 15);
    send_item(OP_RAISE, 1, 8'h00, 0, 64'h5555_AAAA_5555_AAAA, 9);
    send_item(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_item(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_item(OP_UNSUB, 0, 8'hFF, 8'hFF, 0, 0);
    send_item(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_raw(3'd6, 0);
    send_raw(3'd7, 1);
    for (int i = 0; i < 16; i++) send_item(OP_RAISE, 1, 8'(i), 0, rand64(), 8);
    for (int i = 0; i < 33; i++) send_item(OP_SUB, 1, 8'd3, 8'(i), 0, 0);
    send_item(OP_DISPATCH, 1, 0, 0, 0, 0);
    send_item(OP_DISPATCH, 1, 0, 0, 0, 0);
    send_item(OP_DISPATCH, 1, 0, 0, 0, 0);
    send_item(OP_DISPATCH, 1, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++) send_item(OP_NEW_ID, 0, 0, 0, 0, 0);
    send_item(OP_CLEAR, 0, 0, 0, 0, 0);
    send_item(OP_CLEAR, 1, 0, 0, 0, 0);
    send_item(OP_NEW_ID, 0, 0, 0, 0, 0);

    for (int n = 0; n < 77; n++) begin
      k = $urandom_range(0, 99);
      ev = 8'($urandom_range(0, 3));
      if (k < 5) ev = 8'($urandom);
      if (k < 25)
        send_item(OP_SUB, 1'($urandom_range(0, 1)), ev, 8'($urandom_range(0, 3)), 0, 0);
      else if (k < 33)
        send_item(OP_UNSUB, 1'($urandom_range(0, 1)), ev, 8'($urandom_range(0, 3)), 0, 0);
      else if (k < 60)
        send_item(OP_RAISE, 1'($urandom_range(0, 1)), ev, 8'($urandom), rand64(),
                  ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8)));
      else if (k < 88)
        send_item(OP_DISPATCH, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                  rand64(), 4'($urandom));
      else if (k < 94)
        send_item(OP_NEW_ID, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                  rand64(), 4'($urandom));
      else if (k < 96)
        send_item(OP_CLEAR, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                  rand64(), 4'($urandom));
      else
        send_raw(3'($urandom_range(6, 7)), 1'($urandom_range(0, 1)));
    end
    s_axis_tvalid_i <= 1'b0;

    while (dispatch_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (dispatch_sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
